// ===== rtl/bkal_pkg.sv =====
// Shared types and codes for the bounded keyed array list.
// Used by bkal_cell and bounded_keyed_array_list_core; depends on nothing.
package bkal_pkg;

	// Operation codes carried on the mode port.
	typedef enum logic [2:0] {
		MODE_APPEND = 3'd0,
		MODE_INSERT = 3'd1,
		MODE_FRONT  = 3'd2,
		MODE_FIND   = 3'd3,
		MODE_REMOVE = 3'd4,
		MODE_UPDATE = 3'd5,
		MODE_CLEAR  = 3'd6
	} mode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_RANGE   = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	// Broadcast strobes from the control to every cell; at most one is set.
	typedef struct packed {
		logic ins_en; // open a slot at the insert target and load the new entry
		logic rm_en;  // close the slot of the first match
		logic upd_en; // overwrite the payload of every match
	} cell_ctrl_t;

endpackage

// ===== rtl/bkal_cell.sv =====
// One slot of the list: key and payload registers, key compare, neighbor shifting.
// Depends on bkal_pkg (cell_ctrl_t).
module bkal_cell #(
	parameter int IDX          = 0,
	parameter int KEY_BITS     = 16,
	parameter int PAYLOAD_BITS = 32,
	parameter int CW           = 4
) (
	input  logic                    clk,
	input  bkal_pkg::cell_ctrl_t    ctrl,
	input  logic [KEY_BITS-1:0]     new_key,
	input  logic [PAYLOAD_BITS-1:0] new_payload,
	input  logic [CW-1:0]           count,
	input  logic [CW-1:0]           ins_pos,
	input  logic [KEY_BITS-1:0]     left_key,
	input  logic [PAYLOAD_BITS-1:0] left_payload,
	input  logic [KEY_BITS-1:0]     right_key,
	input  logic [PAYLOAD_BITS-1:0] right_payload,
	input  logic                    seen_in,
	output logic [KEY_BITS-1:0]     key_q,
	output logic [PAYLOAD_BITS-1:0] payload_q,
	output logic                    seen_out,
	output logic                    first
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic live;
	logic match;
	logic at_or_past;

	assign live       = IDX_C < count;
	assign match      = live && (key_q == new_key);
	assign at_or_past = seen_in | match;
	assign seen_out   = at_or_past;
	assign first      = match & ~seen_in;

	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (IDX_C == ins_pos) begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end else if (IDX_C > ins_pos && IDX_C <= count) begin
				key_q     <= left_key;
				payload_q <= left_payload;
			end
		end else if (ctrl.rm_en && at_or_past && (IDX_C + CW'(1)) < count) begin
			key_q     <= right_key;
			payload_q <= right_payload;
		end else if (ctrl.upd_en && match) begin
			payload_q <= new_payload;
		end
	end

endmodule

// ===== rtl/bounded_keyed_array_list_core.sv =====
// Top level of the bounded keyed array list: control, cell row, result registers.
// Depends on bkal_pkg and bkal_cell.
//
// A fixed-capacity ordered list of keyed entries kept in a row of CAPACITY
// slot cells. An item is taken when start is high and busy is low; busy stays
// low, so a new item may be offered in every cycle. Each item gives exactly
// one result, registered: done pulses for one cycle in the cycle after the
// item was taken, with status, hit_index, hit_payload and entry_count valid in
// that cycle only. The receiver cannot hold results off, so capture them on
// done. For each operation, every cell compares its key with the
// item's key and loads from its left or right neighbor in the same clock, and
// the first-match mark ripples along the row from slot 0. Results for back to
// back items come back to back. Full list makes append and
// both inserts report full; insert at position also needs the position below
// the count. Find, remove and update report not found when no held entry
// matches; update rewrites every match. Mode seven does nothing and reports
// ok. Slot contents come out of reset undefined; only slots below the count
// are ever looked at.
module bounded_keyed_array_list_core #(
	parameter int CAPACITY     = 8,
	parameter int KEY_BITS     = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  mode,
	input  logic [KEY_BITS-1:0]         entry_key,
	input  logic [PAYLOAD_BITS-1:0]     entry_payload,
	input  logic [$clog2(CAPACITY)-1:0] insert_position,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [$clog2(CAPACITY)-1:0] hit_index,
	output logic [PAYLOAD_BITS-1:0]     hit_payload,
	output logic [$clog2(CAPACITY+1)-1:0] entry_count
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// cell row
	logic [KEY_BITS-1:0]     cell_key   [CAPACITY];
	logic [PAYLOAD_BITS-1:0] cell_pay   [CAPACITY];
	logic [CAPACITY:0]       seen_chain;
	logic [CAPACITY-1:0]     first_vec;

	// control
	logic                 accept;
	bkal_pkg::mode_t      op;
	bkal_pkg::cell_ctrl_t ctrl;
	logic [CW-1:0]        fill_q;
	logic [CW-1:0]        fill_d;
	logic [CW-1:0]        ins_pos;
	logic [CW-1:0]        pos_ext;
	logic                 full;
	logic                 found;
	logic [IW-1:0]        first_idx;
	logic [PAYLOAD_BITS-1:0] first_pay;
	bkal_pkg::status_t    st_d;
	logic [IW-1:0]        idx_d;
	logic [PAYLOAD_BITS-1:0] pay_d;

	// result registers
	logic                    done_q;
	bkal_pkg::status_t       status_q;
	logic [IW-1:0]           hit_index_q;
	logic [PAYLOAD_BITS-1:0] hit_payload_q;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign op      = bkal_pkg::mode_t'(mode);
	assign full    = (fill_q == CAP_C);
	assign pos_ext = CW'(insert_position);
	assign found   = seen_chain[CAPACITY];
	assign seen_chain[0] = 1'b0;

	// First match: one-hot over the row, encoded by OR of independent terms.
	always_comb begin
		first_idx = '0;
		first_pay = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_vec[i]) begin
				first_idx = first_idx | IW'(i);
				first_pay = first_pay | cell_pay[i];
			end
		end
	end

	// Decode the item into cell strobes, next count and result fields.
	always_comb begin
		ctrl    = '0;
		ins_pos = fill_q;
		fill_d  = fill_q;
		st_d    = bkal_pkg::ST_OK;
		idx_d   = '0;
		pay_d   = '0;
		case (op)
			bkal_pkg::MODE_APPEND: begin
				if (full) begin
					st_d = bkal_pkg::ST_FULL;
				end else begin
					ctrl.ins_en = 1'b1;
					fill_d      = fill_q + CW'(1);
				end
			end
			bkal_pkg::MODE_INSERT: begin
				ins_pos = pos_ext;
				if (full) begin
					st_d = bkal_pkg::ST_FULL;
				end else if (pos_ext >= fill_q) begin
					st_d = bkal_pkg::ST_RANGE;
				end else begin
					ctrl.ins_en = 1'b1;
					fill_d      = fill_q + CW'(1);
				end
			end
			bkal_pkg::MODE_FRONT: begin
				ins_pos = '0;
				if (full) begin
					st_d = bkal_pkg::ST_FULL;
				end else begin
					ctrl.ins_en = 1'b1;
					fill_d      = fill_q + CW'(1);
				end
			end
			bkal_pkg::MODE_FIND: begin
				if (found) begin
					idx_d = first_idx;
					pay_d = first_pay;
				end else begin
					st_d = bkal_pkg::ST_MISSING;
				end
			end
			bkal_pkg::MODE_REMOVE: begin
				if (found) begin
					ctrl.rm_en = 1'b1;
					idx_d      = first_idx;
					fill_d     = fill_q - CW'(1);
				end else begin
					st_d = bkal_pkg::ST_MISSING;
				end
			end
			bkal_pkg::MODE_UPDATE: begin
				if (found) begin
					ctrl.upd_en = 1'b1;
				end else begin
					st_d = bkal_pkg::ST_MISSING;
				end
			end
			bkal_pkg::MODE_CLEAR: begin
				fill_d = '0;
			end
			default: begin
			end
		endcase
		if (!accept) begin
			ctrl = '0;
		end
	end

	// Row of slot cells; slot 0 has no left neighbor, the last none on the right.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [KEY_BITS-1:0]     lk;
		logic [PAYLOAD_BITS-1:0] lp;
		logic [KEY_BITS-1:0]     rk;
		logic [PAYLOAD_BITS-1:0] rp;

		if (g == 0) begin : g_left_edge
			assign lk = '0;
			assign lp = '0;
		end else begin : g_left
			assign lk = cell_key[g-1];
			assign lp = cell_pay[g-1];
		end

		if (g == CAPACITY - 1) begin : g_right_edge
			assign rk = cell_key[g];
			assign rp = cell_pay[g];
		end else begin : g_right
			assign rk = cell_key[g+1];
			assign rp = cell_pay[g+1];
		end

		bkal_cell #(
			.IDX          (g),
			.KEY_BITS     (KEY_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS),
			.CW           (CW)
		) u_cell (
			.clk           (clk),
			.ctrl          (ctrl),
			.new_key       (entry_key),
			.new_payload   (entry_payload),
			.count         (fill_q),
			.ins_pos       (ins_pos),
			.left_key      (lk),
			.left_payload  (lp),
			.right_key     (rk),
			.right_payload (rp),
			.seen_in       (seen_chain[g]),
			.key_q         (cell_key[g]),
			.payload_q     (cell_pay[g]),
			.seen_out      (seen_chain[g+1]),
			.first         (first_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				fill_q <= fill_d;
			end
		end
	end

	// result payload, qualified by done
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= st_d;
			hit_index_q   <= idx_d;
			hit_payload_q <= pay_d;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign hit_index   = hit_index_q;
	assign hit_payload = hit_payload_q;
	assign entry_count = fill_q;

	// count never exceeds the row
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CAP_C)
		else $error("entry count above capacity");

	// one result for each item taken, in the cycle after
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("result strobe missing after item");

	// at most one slot is marked as the first match
	a_first_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_vec))
		else $error("more than one first match");

	// an item that fails leaves the count alone
	a_fail_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (st_d == bkal_pkg::ST_MISSING || st_d == bkal_pkg::ST_FULL
			|| st_d == bkal_pkg::ST_RANGE)) |=> $stable(fill_q))
		else $error("count changed on failed item");

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for bounded_keyed_array_list_core: directed and random list operations
// are checked against a behavioral copy of the list kept in the bench.
// Depends on bkal_pkg and the list core RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP   = 8;
	localparam int KEY_W = 16;
	localparam int PAY_W = 32;
	localparam int IDX_W = $clog2(CAP);
	localparam int CNT_W = $clog2(CAP + 1);

	localparam logic [2:0] MODE_NOP = 3'd7; // unused code, list must ignore it

	localparam int RANDOM_OPS = 1100;
	localparam int CALM_TAIL  = 150;  // last items go out with no gaps
	localparam int PHASE_LEN  = 40;
	localparam int STALL_MAX  = 1000; // cycles with no traffic before giving up
	localparam int MAX_REPORT = 10;

	// One list operation plus the idle cycles the driver leaves after it is taken.
	typedef struct {
		logic [2:0]       mode;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
		logic [IDX_W-1:0] pos;
		int unsigned      gap_after;
	} list_op_t;

	typedef struct {
		bkal_pkg::status_t status;
		logic [IDX_W-1:0]  idx;
		logic [PAY_W-1:0]  payload;
		logic [CNT_W-1:0]  count;
	} list_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [2:0]       mode = 3'd0;
	logic [KEY_W-1:0] entry_key = '0;
	logic [PAY_W-1:0] entry_payload = '0;
	logic [IDX_W-1:0] insert_position = '0;
	logic             busy;
	logic             done;
	logic [1:0]       status;
	logic [IDX_W-1:0] hit_index;
	logic [PAY_W-1:0] hit_payload;
	logic [CNT_W-1:0] entry_count;

	bounded_keyed_array_list_core #(
		.CAPACITY(CAP),
		.KEY_BITS(KEY_W),
		.PAYLOAD_BITS(PAY_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.entry_key(entry_key),
		.entry_payload(entry_payload),
		.insert_position(insert_position),
		.done(done),
		.status(status),
		.hit_index(hit_index),
		.hit_payload(hit_payload),
		.entry_count(entry_count)
	);

	always #2 clk = ~clk;

	// Bench-side copy of the list. Slots at or above held_count are stale and never read.
	logic [KEY_W-1:0] held_keys [CAP];
	logic [PAY_W-1:0] held_payloads [CAP];
	int               held_count = 0;

	list_op_t     pending_ops[$];     // items not yet offered
	list_result_t pending_results[$]; // predicted results awaiting done
	list_op_t     cur_op;             // item currently on the input ports

	int unsigned ops_planned = 0;
	int unsigned ops_taken = 0;
	int unsigned results_seen = 0;
	int unsigned faults = 0;
	int unsigned idle_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned mode_seen [8];
	int unsigned status_seen [4];

	// Shift slots pos..count-1 one place right and drop the new entry into pos.
	function automatic void slot_open(int pos, list_op_t op);
		for (int i = held_count; i > pos; i--) begin
			held_keys[i]     = held_keys[i-1];
			held_payloads[i] = held_payloads[i-1];
		end
		held_keys[pos]     = op.key;
		held_payloads[pos] = op.payload;
		held_count++;
	endfunction

	// Apply one item to the bench list and return the result the core should give.
	function automatic list_result_t list_apply(list_op_t op);
		list_result_t r;
		int           hit;
		bit           any;
		r.status  = bkal_pkg::ST_OK;
		r.idx     = '0;
		r.payload = '0;
		hit = -1;
		any = 1'b0;
		for (int i = 0; i < held_count; i++) begin
			if (hit < 0 && held_keys[i] == op.key)
				hit = i;
		end
		case (op.mode)
			bkal_pkg::MODE_APPEND: begin
				if (held_count >= CAP)
					r.status = bkal_pkg::ST_FULL;
				else
					slot_open(held_count, op);
			end
			bkal_pkg::MODE_INSERT: begin
				// fullness wins over a bad position
				if (held_count >= CAP)
					r.status = bkal_pkg::ST_FULL;
				else if (int'(op.pos) >= held_count)
					r.status = bkal_pkg::ST_RANGE;
				else
					slot_open(int'(op.pos), op);
			end
			bkal_pkg::MODE_FRONT: begin
				if (held_count >= CAP)
					r.status = bkal_pkg::ST_FULL;
				else
					slot_open(0, op);
			end
			bkal_pkg::MODE_FIND: begin
				if (hit < 0) begin
					r.status = bkal_pkg::ST_MISSING;
				end else begin
					r.idx     = IDX_W'(hit);
					r.payload = held_payloads[hit];
				end
			end
			bkal_pkg::MODE_REMOVE: begin
				if (hit < 0) begin
					r.status = bkal_pkg::ST_MISSING;
				end else begin
					r.idx = IDX_W'(hit);
					for (int i = hit; i + 1 < held_count; i++) begin
						held_keys[i]     = held_keys[i+1];
						held_payloads[i] = held_payloads[i+1];
					end
					held_count--;
				end
			end
			bkal_pkg::MODE_UPDATE: begin
				// every match is rewritten, not just the first
				for (int i = 0; i < held_count; i++) begin
					if (held_keys[i] == op.key) begin
						held_payloads[i] = op.payload;
						any = 1'b1;
					end
				end
				if (!any)
					r.status = bkal_pkg::ST_MISSING;
			end
			bkal_pkg::MODE_CLEAR: begin
				held_count = 0;
			end
			default: begin
				// unused code: no change, status ok
			end
		endcase
		r.count = CNT_W'(held_count);
		return r;
	endfunction

	function automatic list_op_t list_op(logic [2:0] m, logic [KEY_W-1:0] k,
			logic [PAY_W-1:0] p, logic [IDX_W-1:0] pos);
		list_op_t op;
		op.mode      = m;
		op.key       = k;
		op.payload   = p;
		op.pos       = pos;
		op.gap_after = 0;
		return op;
	endfunction

	// Driver: an item is taken on an edge where start is high and busy low; the
	// prediction is made right then, against the list as it stood before the item.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				list_result_t r;
				r = list_apply(cur_op);
				pending_results.push_back(r);
				mode_seen[cur_op.mode]++;
				status_seen[r.status]++;
				ops_taken++;
				idle_left = cur_op.gap_after;
			end
			if (start && busy) begin
				// item not taken yet: hold it
			end else if (idle_left != 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				cur_op = pending_ops.pop_front();
				mode            <= cur_op.mode;
				entry_key       <= cur_op.key;
				entry_payload   <= cur_op.payload;
				insert_position <= cur_op.pos;
				start           <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: done marks a result for exactly one cycle; check it against the
	// oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			list_result_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				faults++;
				if (faults <= MAX_REPORT)
					$display("%0t: result with nothing expected: st %0d idx %0d pay %h cnt %0d",
						$realtime, status, hit_index, hit_payload, entry_count);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status || hit_index !== want.idx ||
						hit_payload !== want.payload || entry_count !== want.count) begin
					faults++;
					if (faults <= MAX_REPORT) begin
						$display("%0t: result %0d mismatch: exp st %0d idx %0d pay %h cnt %0d,",
							$realtime, results_seen, want.status, want.idx,
							want.payload, want.count);
						$display("    got st %0d idx %0d pay %h cnt %0d",
							status, hit_index, hit_payload, entry_count);
					end
				end
			end
		end
	end

	// Watchdog on traffic: no item taken and no result for too long ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_MAX) begin
				$display("%0t: no traffic for %0d cycles", $realtime, quiet_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [KEY_W-1:0] key_pool [6];
		int               cut [3][8];
		int               phase;
		int               roll;
		bit               calm;
		list_op_t         op;

		// Cumulative percent thresholds per mode code: grow, shrink, mixed.
		cut = '{'{25, 45, 60, 75, 85, 95, 97, 100},
			'{10, 18, 25, 45, 80, 95, 98, 100},
			'{15, 30, 40, 60, 80, 94, 97, 100}};
		phase = 0;
		calm  = 1'b0;

		// Directed: empty-list misses, range on empty, extremes of key and
		// payload, duplicate keys, full list, position at and past the count,
		// removes at the front and inside the list, unused code, clear.
		pending_ops.push_back(list_op(bkal_pkg::MODE_FIND,   16'h0005, 32'h0, 3'd0));
		pending_ops.push_back(list_op(bkal_pkg::MODE_REMOVE, 16'h0005, 32'h0, 3'd0));
		pending_ops.push_back(list_op(bkal_pkg::MODE_UPDATE, 16'h0005, 32'h1111_1111, 3'd0));
		pending_ops.push_back(list_op(bkal_pkg::MODE_INSERT, 16'h0009, 32'h2222_2222, 3'd0));
		pending_ops.push_back(list_op(bkal_pkg::MODE_APPEND, 16'h0000, 32'h0000_0000, 3'd7));
		pending_ops.push_back(list_op(bkal_pkg::MODE_APPEND, 16'hFFFF, 32'hFFFF_FFFF, 3'd0));
		pending_ops.push_back(list_op(bkal_pkg::MODE_FRONT,  16'h0005, 32'hA5A5_A5A5, 3'd3));
		pending_ops.push_back(list_op(bkal_pkg::MODE_INSERT, 16'h0005, 32'h5A5A_5A5A, 3'd2));
		pending_ops.push_back(list_op(bkal_pkg::MODE_INSERT, 16'h0001, 32'h3333_3333, 3'd4));
		pending_ops.push_back(list_op(bkal_pkg::MODE_INSERT, 16'h0001, 32'h3333_3333, 3'd7));
		pending_ops.push_back(list_op(bkal_pkg::MODE_UPDATE, 16'h0005, 32'h1234_5678, 3'd0));
		pending_ops.push_back(list_op(bkal_pkg::MODE_FIND,   16'h0005, 32'h0, 3'd0));
		pending_ops.push_back(list_op(bkal_pkg::MODE_FIND,   16'hFFFF, 32'h0, 3'd0));
		pending_ops.push_back(list_op(MODE_NOP,              16'hFFFF, 32'hFFFF_FFFF, 3'd7));
		pending_ops.push_back(list_op(bkal_pkg::MODE_APPEND, 16'h0001, 32'h0000_0001, 3'd0));
		pending_ops.push_back(list_op(bkal_pkg::MODE_APPEND, 16'h0002, 32'h8000_0000, 3'd0));
		pending_ops.push_back(list_op(bkal_pkg::MODE_APPEND, 16'h0003, 32'h7FFF_FFFF, 3'd0));
		pending_ops.push_back(list_op(bkal_pkg::MODE_INSERT, 16'h0004, 32'hDEAD_0004, 3'd7));
		pending_ops.push_back(list_op(bkal_pkg::MODE_INSERT, 16'h0004, 32'hBEEF_0004, 3'd6));
		pending_ops.push_back(list_op(bkal_pkg::MODE_APPEND, 16'h0006, 32'h6666_6666, 3'd0));
		pending_ops.push_back(list_op(bkal_pkg::MODE_FRONT,  16'h0007, 32'h7777_7777, 3'd0));
		pending_ops.push_back(list_op(bkal_pkg::MODE_INSERT, 16'h0008, 32'h8888_8888, 3'd7));
		pending_ops.push_back(list_op(bkal_pkg::MODE_REMOVE, 16'h0005, 32'h0, 3'd0));
		pending_ops.push_back(list_op(bkal_pkg::MODE_REMOVE, 16'h0004, 32'h0, 3'd0));
		pending_ops.push_back(list_op(bkal_pkg::MODE_CLEAR,  16'h0000, 32'h0, 3'd0));

		// Random: phases that lean toward filling or draining the list, keys
		// mostly from a small pool so finds, removes and updates hit.
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n % PHASE_LEN == 0) begin
				phase = $urandom_range(0, 2);
				calm  = ($urandom_range(0, 3) == 0);
				foreach (key_pool[i])
					key_pool[i] = KEY_W'($urandom);
				if ($urandom_range(0, 1))
					key_pool[0] = '0;
				if ($urandom_range(0, 1))
					key_pool[1] = '1;
			end
			roll = $urandom_range(0, 99);
			op.mode = MODE_NOP;
			for (int m = 7; m >= 0; m--) begin
				if (roll < cut[phase][m])
					op.mode = 3'(m);
			end
			if ($urandom_range(0, 4) == 0)
				op.key = KEY_W'($urandom);
			else
				op.key = key_pool[$urandom_range(0, 5)];
			roll = $urandom_range(0, 19);
			if (roll == 0)
				op.payload = '0;
			else if (roll == 1)
				op.payload = '1;
			else
				op.payload = PAY_W'($urandom);
			op.pos = IDX_W'($urandom_range(0, CAP - 1));
			if (calm || n >= RANDOM_OPS - CALM_TAIL || $urandom_range(0, 3) != 0)
				op.gap_after = 0;
			else
				op.gap_after = $urandom_range(1, 4);
			pending_ops.push_back(op);
		end
		ops_planned = pending_ops.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (ops_taken < ops_planned || pending_results.size() != 0)
			@(posedge clk);
		// results are registered; wait on so that any stray done is still seen
		repeat (4) @(posedge clk);

		$display("%0d items taken, %0d results checked; appends %0d inserts %0d fronts %0d",
			ops_taken, results_seen, mode_seen[bkal_pkg::MODE_APPEND],
			mode_seen[bkal_pkg::MODE_INSERT], mode_seen[bkal_pkg::MODE_FRONT]);
		$display("finds %0d removes %0d updates %0d clears %0d unused %0d",
			mode_seen[bkal_pkg::MODE_FIND], mode_seen[bkal_pkg::MODE_REMOVE],
			mode_seen[bkal_pkg::MODE_UPDATE], mode_seen[bkal_pkg::MODE_CLEAR],
			mode_seen[MODE_NOP]);
		$display("outcomes: ok %0d, full %0d, bad position %0d, key missing %0d; %0d faults",
			status_seen[bkal_pkg::ST_OK], status_seen[bkal_pkg::ST_FULL],
			status_seen[bkal_pkg::ST_RANGE], status_seen[bkal_pkg::ST_MISSING], faults);
		if (faults == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
